// File: src/csd_pkg.sv
// shared types and constants for the checksummed sentence decoder
// no dependencies; used by csd_step and checksummed_sentence_decoder
package csd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned CNT_W = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPA    = 8'h41;
  localparam logic [7:0] CH_UPF    = 8'h46;

  localparam logic [23:0] NAME_CHA = 24'h434841;
  localparam logic [23:0] NAME_ACC = 24'h414343;
  localparam logic [23:0] NAME_SHO = 24'h53484F;
  localparam logic [23:0] NAME_REV = 24'h524556;
  localparam logic [23:0] NAME_RES = 24'h524553;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ERROR = 3'd1,
    EV_CHA   = 3'd2,
    EV_ACC   = 3'd3,
    EV_SHO   = 3'd4,
    EV_REV   = 3'd5,
    EV_RES   = 3'd6
  } event_kind_e;

  typedef enum logic [2:0] {
    ERR_START     = 3'd0,
    ERR_LONG      = 3'd1,
    ERR_CHK_LONG  = 3'd2,
    ERR_CHK_SHORT = 3'd3,
    ERR_HEX       = 3'd4,
    ERR_PARSE     = 3'd5
  } error_code_e;

  typedef struct packed {
    phase_e             phase;
    logic [CNT_W-1:0]   char_count;
    logic [7:0]         running_xor;
    logic [23:0]        type_match;
    logic [2:0]         type_len;
    logic [2:0]         field_index;
    logic [2:0][15:0]   field_values;
    logic               digits_ended;
    logic [7:0]         received_check;
    logic               in_field;
    logic               payload_cut;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] value_c;
    logic [15:0] value_b;
    logic [15:0] value_a;
    error_code_e error_code;
    event_kind_e event_kind;
  } dec_result_t;

endpackage

// File: src/checksummed_sentence_decoder.sv
// top level of the checksummed sentence decoder: input register, sentence state, result register
// depends on csd_pkg and csd_step
//
// usage
// - slave channel takes one received character per word in s_axis_tdata_i
// - master channel gives exactly one result word per character: event kind,
//   error code and three decimal values (event none for characters that end nothing)
// - an accepted word is registered in the input register; its result is then registered
//   in the result register and presented on the master side
// - throughput: one word per cycle while the receiver takes results; the sentence state
//   is updated by a single pass of logic between the input register and the result register
// - reset clears the valid flags of both registers and returns the parser to waiting
//   for a start character; no sentence state survives reset
// - when the receiver stalls, the pending result holds, the input register fills
//   and then s_axis_tready_o drops; no result is lost or repeated
// - MAX_PAYLOAD limits payload characters to MAX_PAYLOAD-1 per sentence
module checksummed_sentence_decoder import csd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_in[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // event_kind[2:0], error_code[5:3], value_a[21:6],
                                        // value_b[37:22], value_c[53:38], zero fill
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  dec_result_t out_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  dec_result_t result_d;
  logic        advance;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  csd_step #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (in_valid_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (in_valid_q && advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

`ifndef ASSERT_OFF
  a_code_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_kind != EV_ERROR) |-> out_q.error_code == ERR_START)
    else $error("error code set on a non-error event");

  a_values_only_on_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_kind == EV_NONE || out_q.event_kind == EV_ERROR)) |->
    (out_q.value_a == 16'd0 && out_q.value_b == 16'd0 && out_q.value_c == 16'd0))
    else $error("values set on an event without a message");

  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_CHECK) |-> (state_q.char_count <= CNT_W'(2)))
    else $error("checksum digit count overran");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_PAYLOAD) |-> (state_q.char_count <= CNT_W'(MAX_PAYLOAD)))
    else $error("payload count passed its limit");

  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q)
    else $error("processed word produced no result");
`endif

endmodule

// File: src/csd_step.sv
// next-state and result logic for one received character
// depends on csd_pkg
module csd_step import csd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  dec_state_t  state_i,
  input  logic [7:0]  byte_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  always_comb begin
    dec_state_t  nxt;
    dec_result_t res;
    event_kind_e kind;
    logic [1:0]  need;
    logic [15:0] v;
    logic        is_digit;
    logic        is_hex_af;

    nxt       = state_i;
    res       = '0;
    kind      = EV_NONE;
    need      = 2'd0;
    v         = 16'd0;
    is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    is_hex_af = (byte_i >= CH_UPA) && (byte_i <= CH_UPF);

    case (state_i.phase)
      PH_PAYLOAD: begin
        if (state_i.char_count >= CNT_W'(MAX_PAYLOAD)) begin
          nxt.phase          = PH_WAIT;
          nxt.char_count     = '0;
          res.event_kind     = EV_ERROR;
          res.error_code     = ERR_LONG;
        end else if (byte_i == CH_LF || byte_i == CH_DOLLAR) begin
          nxt.phase          = PH_WAIT;
          nxt.char_count     = '0;
          res.event_kind     = EV_ERROR;
          res.error_code     = ERR_START;
        end else if (byte_i == CH_STAR) begin
          nxt.phase          = PH_CHECK;
          nxt.char_count     = '0;
        end else begin
          nxt.char_count = state_i.char_count + CNT_W'(1);
          if (!state_i.payload_cut) begin
            if (byte_i == CH_NUL) begin
              nxt.payload_cut = 1'b1;
            end else begin
              nxt.running_xor = state_i.running_xor ^ byte_i;
              if (byte_i == CH_COMMA) begin
                nxt.in_field = 1'b0;
              end else begin
                if (!state_i.in_field) begin
                  nxt.in_field     = 1'b1;
                  nxt.digits_ended = 1'b0;
                  if (state_i.field_index != 3'd7) begin
                    nxt.field_index = state_i.field_index + 3'd1;
                  end
                end
                case (nxt.field_index)
                  3'd1: begin
                    if (state_i.type_len < 3'd3) begin
                      nxt.type_match = {state_i.type_match[15:0], byte_i};
                    end
                    if (state_i.type_len < 3'd4) begin
                      nxt.type_len = state_i.type_len + 3'd1;
                    end
                  end
                  3'd2, 3'd3, 3'd4: begin
                    v = state_i.field_values[2'(nxt.field_index - 3'd2)];
                    if (!nxt.digits_ended && is_digit) begin
                      nxt.field_values[2'(nxt.field_index - 3'd2)] =
                        (v << 3) + (v << 1) + {12'd0, byte_i[3:0]};
                    end else begin
                      nxt.digits_ended = 1'b1;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
        end
      end
      PH_CHECK: begin
        if (byte_i == CH_LF) begin
          nxt.phase      = PH_WAIT;
          nxt.char_count = '0;
          if (state_i.char_count < CNT_W'(2)) begin
            res.event_kind = EV_ERROR;
            res.error_code = ERR_CHK_SHORT;
          end else begin
            if (state_i.type_len == 3'd3) begin
              case (state_i.type_match)
                NAME_CHA: begin kind = EV_CHA; need = 2'd1; end
                NAME_ACC: begin kind = EV_ACC; need = 2'd1; end
                NAME_SHO: begin kind = EV_SHO; need = 2'd2; end
                NAME_REV: begin kind = EV_REV; need = 2'd1; end
                NAME_RES: begin kind = EV_RES; need = 2'd3; end
                default:  begin kind = EV_NONE; need = 2'd0; end
              endcase
            end
            if (state_i.running_xor != state_i.received_check || kind == EV_NONE ||
                state_i.field_index != ({1'b0, need} + 3'd1)) begin
              res.event_kind = EV_ERROR;
              res.error_code = ERR_PARSE;
            end else begin
              res.event_kind = kind;
              res.value_a    = state_i.field_values[0];
              res.value_b    = state_i.field_values[1];
              res.value_c    = state_i.field_values[2];
            end
          end
        end else if (state_i.char_count >= CNT_W'(2)) begin
          nxt.phase      = PH_WAIT;
          nxt.char_count = '0;
          res.event_kind = EV_ERROR;
          res.error_code = ERR_CHK_LONG;
        end else if (is_digit) begin
          nxt.received_check = {state_i.received_check[3:0], byte_i[3:0]};
          nxt.char_count     = state_i.char_count + CNT_W'(1);
        end else if (is_hex_af) begin
          nxt.received_check = {state_i.received_check[3:0], byte_i[3:0] + 4'd9};
          nxt.char_count     = state_i.char_count + CNT_W'(1);
        end else begin
          nxt.phase      = PH_WAIT;
          nxt.char_count = '0;
          res.event_kind = EV_ERROR;
          res.error_code = ERR_HEX;
        end
      end
      default: begin
        if (byte_i != CH_DOLLAR) begin
          nxt.phase      = PH_WAIT;
          res.event_kind = EV_ERROR;
          res.error_code = ERR_START;
        end else begin
          nxt       = '0;
          nxt.phase = PH_PAYLOAD;
        end
      end
    endcase

    state_o  = nxt;
    result_o = res;
  end

endmodule
